// File: src/ssh_pkg.sv
// Package for the spaced seed hit search core: widths, register codes,
// shared structs and the range-clamp helpers.
// No dependencies; every other file in src imports it.
package ssh_pkg;

  localparam int MaxSpan  = 16;
  localparam int SymW     = 2;
  localparam int LetterW  = 4;
  localparam int AgeW     = $clog2(MaxSpan);
  localparam int SpanW    = 5;
  localparam int CycW     = 7;
  localparam int ResW     = 6;
  localparam int PosW     = 16;
  localparam int CntW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int MaxCycle = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMatchMatrix = 3'd0,
    CfgSeedLetters = 3'd1,
    CfgSeedSpan    = 3'd2,
    CfgCyclicEn    = 3'd3,
    CfgCycleSize   = 3'd4,
    CfgCycleMask   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0]      match_matrix;
    logic [63:0]      seed_letters;
    logic [SpanW-1:0] seed_span;
    logic             cyclic_enable;
    logic [CycW-1:0]  cycle_len;
    logic [63:0]      cycle_position_mask;
  } cfg_t;

  typedef logic [MaxSpan-1:0][SymW-1:0] win_t;

  // Window stage contents handed to the hit stage
  typedef struct packed {
    logic            valid;
    logic            last;
    win_t            win;
    logic [PosW-1:0] pos;
    logic [ResW-1:0] res;
  } win_stage_t;

  // Clamp the seed span into 1..MaxSpan
  function automatic logic [SpanW-1:0] eff_span(input logic [SpanW-1:0] s);
    logic [SpanW-1:0] r;
    r = s;
    if (s == '0) r = SpanW'(1);
    else if (s > SpanW'(MaxSpan)) r = SpanW'(MaxSpan);
    return r;
  endfunction

  // Clamp the cycle size into 1..MaxCycle
  function automatic logic [CycW-1:0] eff_cycle(input logic [CycW-1:0] c);
    logic [CycW-1:0] r;
    r = c;
    if (c == '0) r = CycW'(1);
    else if (c > CycW'(MaxCycle)) r = CycW'(MaxCycle);
    return r;
  endfunction

endpackage

// File: src/spaced_seed_hit_search_core.sv
// Spaced seed hit search core: top level.
// Instantiates ssh_cfg_regs, ssh_window and ssh_hit_accum; uses ssh_pkg.
//
// Usage:
//   Alignment symbols enter on the input channel (in_valid_i / in_stall_o),
//   one per transfer, with last_symbol_i marking the final symbol of an
//   alignment. Only the last symbol produces a result on the output channel
//   (out_valid_o / out_stall_i): hit flag, first hit start, hit count.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no alignment is in flight.
// Throughput: one symbol per cycle while in_stall_o is low, set by the single
//   window stage feeding the parallel seed compare.
// Result path: the last symbol's transfer loads the window register, and the
//   result register loads from it when the hit stage advances past that symbol.
// Reset: configuration returns to its reset values, the window, position,
//   residue and accumulators clear, and no result is pending.
// Stall: a stalled result holds; symbols keep flowing until another last
//   symbol reaches the hit stage while the result register is still full,
//   then in_stall_o rises until the result is transferred.
module spaced_seed_hit_search_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ssh_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ssh_pkg::SymW-1:0]     align_symbol_i,
  input  logic                         last_symbol_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_found_o,
  output logic [ssh_pkg::PosW-1:0]     first_hit_start_o,
  output logic [ssh_pkg::CntW-1:0]     hit_count_o
);
  import ssh_pkg::*;

  cfg_t       cfg;
  win_stage_t stage;
  logic       advance;

  ssh_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ssh_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .align_symbol_i (align_symbol_i),
    .last_symbol_i  (last_symbol_i),
    .advance_i      (advance),
    .stage_o        (stage)
  );

  ssh_hit_accum u_hit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .stage_i           (stage),
    .advance_o         (advance),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_found_o       (hit_found_o),
    .first_hit_start_o (first_hit_start_o),
    .hit_count_o       (hit_count_o)
  );

endmodule

// File: src/ssh_cfg_regs.sv
// Configuration register file of the spaced seed hit search core.
// Depends on ssh_pkg for register codes and the cfg_t struct.
module ssh_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ssh_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ssh_pkg::CfgDataW-1:0]     cfg_data_i,
  output ssh_pkg::cfg_t                    cfg_o
);
  import ssh_pkg::*;

  cfg_t cfg_q;

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_matrix        <= '0;
      cfg_q.seed_letters        <= '0;
      cfg_q.seed_span           <= SpanW'(1);
      cfg_q.cyclic_enable       <= 1'b0;
      cfg_q.cycle_len           <= CycW'(1);
      cfg_q.cycle_position_mask <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMatchMatrix: cfg_q.match_matrix        <= cfg_data_i;
        CfgSeedLetters: cfg_q.seed_letters        <= cfg_data_i;
        CfgSeedSpan:    cfg_q.seed_span           <= cfg_data_i[SpanW-1:0];
        CfgCyclicEn:    cfg_q.cyclic_enable       <= cfg_data_i[0];
        CfgCycleSize:   cfg_q.cycle_len           <= cfg_data_i[CycW-1:0];
        CfgCycleMask:   cfg_q.cycle_position_mask <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/ssh_window.sv
// Input stage: symbol window shift line, saturating position counter and
// end residue counter. Depends on ssh_pkg.
module ssh_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssh_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ssh_pkg::SymW-1:0]    align_symbol_i,
  input  logic                        last_symbol_i,
  input  logic                        advance_i,
  output ssh_pkg::win_stage_t         stage_o
);
  import ssh_pkg::*;

  logic            valid_q, valid_d;
  logic            last_q;
  logic            restart_q;
  win_t            win_q, win_d, win_base;
  logic [PosW-1:0] pos_q, pos_d, pos_base;
  logic [ResW-1:0] res_q, res_d, res_base;
  logic [CycW-1:0] res_inc;
  logic [CycW-1:0] cyc;
  logic            in_xfer;

  assign in_stall_o = valid_q && !advance_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cyc        = eff_cycle(cfg_i.cycle_len);

  // Start from a cleared stream after a last symbol
  always_comb begin
    win_base = restart_q ? '0 : win_q;
    pos_base = restart_q ? '0 : pos_q;
    res_base = restart_q ? '0 : res_q;
    win_d    = {win_base[MaxSpan-2:0], align_symbol_i};
    pos_d    = (pos_base == '1) ? pos_base : pos_base + PosW'(1);
    res_inc  = CycW'(res_base) + CycW'(1);
    res_d    = (res_inc >= cyc) ? '0 : res_inc[ResW-1:0];
    valid_d  = in_xfer ? 1'b1 : (advance_i ? 1'b0 : valid_q);
  end

  // Load a transfer into the stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
      restart_q <= 1'b0;
      win_q     <= '0;
      pos_q     <= '0;
      res_q     <= '0;
    end else begin
      valid_q <= valid_d;
      if (in_xfer) begin
        last_q    <= last_symbol_i;
        restart_q <= last_symbol_i;
        win_q     <= win_d;
        pos_q     <= pos_d;
        res_q     <= res_d;
      end
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.last  = last_q;
  assign stage_o.win   = win_q;
  assign stage_o.pos   = pos_q;
  assign stage_o.res   = res_q;

  // A last symbol always enters the stage flagged as last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && last_symbol_i) |=> (valid_q && last_q && restart_q))
    else $error("last symbol not captured");

endmodule

// File: src/ssh_hit_accum.sv
// Hit stage: seed compare against the window, hit accumulators and the
// result register. Depends on ssh_pkg.
module ssh_hit_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssh_pkg::cfg_t               cfg_i,
  input  ssh_pkg::win_stage_t         stage_i,
  output logic                        advance_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_found_o,
  output logic [ssh_pkg::PosW-1:0]    first_hit_start_o,
  output logic [ssh_pkg::CntW-1:0]    hit_count_o
);
  import ssh_pkg::*;

  logic [SpanW-1:0]   span;
  logic [MaxSpan-1:0] letter_ok;
  logic               win_match;
  logic               allowed;
  logic               hit;
  logic               out_load;

  logic               found_q, found_d;
  logic [PosW-1:0]    first_q, first_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  logic               out_valid_q;
  logic               out_found_q;
  logic [PosW-1:0]    out_first_q;
  logic [CntW-1:0]    out_cnt_q;

  assign span = eff_span(cfg_i.seed_span);

  // Check each seed letter against the symbol of its age in the window
  always_comb begin
    logic [SpanW-1:0]   age;
    logic [LetterW-1:0] letter;
    logic [SymW-1:0]    sym;
    for (int i = 0; i < MaxSpan; i++) begin
      age          = span - SpanW'(i) - SpanW'(1);
      letter       = cfg_i.seed_letters[i*LetterW +: LetterW];
      sym          = stage_i.win[age[AgeW-1:0]];
      letter_ok[i] = (SpanW'(i) >= span) || cfg_i.match_matrix[{sym, letter}];
    end
  end

  assign win_match = &letter_ok;
  assign allowed   = !cfg_i.cyclic_enable || cfg_i.cycle_position_mask[stage_i.res];
  assign hit       = (stage_i.pos >= PosW'(span)) && allowed && win_match;

  // Advance a valid stage unless a last symbol waits on a full, stalled result register
  assign advance_o = stage_i.valid &&
                     (!stage_i.last || !out_valid_q || !out_stall_i);
  assign out_load  = advance_o && stage_i.last;

  // Update found flag, first start and saturating count
  always_comb begin
    found_d = found_q | hit;
    first_d = (hit && !found_q) ? stage_i.pos - PosW'(span) : first_q;
    cnt_d   = (hit && cnt_q != '1) ? cnt_q + CntW'(1) : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      first_q <= '0;
      cnt_q   <= '0;
    end else if (advance_o) begin
      if (stage_i.last) begin
        found_q <= 1'b0;
        first_q <= '0;
        cnt_q   <= '0;
      end else begin
        found_q <= found_d;
        first_q <= first_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  // Hold the result until it is transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= found_d;
      out_first_q <= first_d;
      out_cnt_q   <= cnt_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hit_found_o       = out_found_q;
  assign first_hit_start_o = out_first_q;
  assign hit_count_o       = out_cnt_q;

  // A nonzero count implies a first hit was recorded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (cnt_q == '0))
    else $error("hit count without found flag");

  // Accumulators are cleared after a result is taken in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (!found_q && cnt_q == '0 && first_q == '0))
    else $error("accumulators not cleared after result");

  // A result loads only from a last symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (stage_i.valid && stage_i.last))
    else $error("result loaded without last symbol");

endmodule
